### sv/ggs_pkg.sv
`timescale 1ns / 1ps

package ggs_pkg;

    localparam int MAX_ROWS  = 1024;
    localparam int MAX_COLS  = 1024;

    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int RCNT_W    = $clog2(MAX_ROWS + 1);
    localparam int CCNT_W    = $clog2(MAX_COLS + 1);

    localparam int DATA_W    = 32;
    localparam int SIZE_W    = 11;
    localparam int IDX_W     = 10;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int QUOT_W    = PROD_W - 16;

    localparam int NUM_BANKS = 3;
    localparam int BANK_W    = 2;
    localparam int NUM_PTS   = 4;

    localparam int APB_AW    = 4;
    localparam int APB_DW    = 32;

    localparam logic [SIZE_W-1:0] GRID_SIZE_RESET = SIZE_W'(1024);
    localparam logic [DATA_W-1:0] INV_SPACE_RESET = DATA_W'(65536);

    typedef enum logic [1:0] {
        REG_GRID_ROWS = 2'd0,
        REG_GRID_COLS = 2'd1,
        REG_INV_ROW   = 2'd2,
        REG_INV_COL   = 2'd3
    } t_reg_idx;

    typedef logic [BANK_W-1:0] t_bank;

    // one difference on its way to the multiplier
    typedef struct packed {
        logic [DATA_W-1:0] mag;
        logic              neg;
        logic              sh17;
    } t_lane;

    // position and framing of one result
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
        logic             fend;
    } t_tag;

endpackage

### sv/ggs_ram.sv
`timescale 1ns / 1ps

module ggs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold the read word until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/grid_gradient_stencil.sv
`timescale 1ns / 1ps

// Streaming 2-D finite-difference gradient over a raster-order grid.
// Input channel (i_in_valid / o_in_ready, i_sample): one signed Q16.16 sample
// per transaction, row by row, each row left to right.
// Output channel (o_out_valid / i_out_ready): one grid point per transaction,
// tagged with its row and column; o_last_of_run marks the final result caused
// by a sample, o_frame_end the result of the last grid point.
// Sample (r,c) yields point (r-1,c-1); in the last column also (r-1,c); in the
// last row also (r,c-1) and at the last column (r,c). Row 0 and column 0
// samples yield nothing.
// Path: input register, point sequencer, then difference, multiply, round and
// output registers. Throughput: one sample per cycle where it yields at most one
// result and the output does not stall; a sample yielding more results holds
// the point sequencer until all are issued. Three row banks of MAX_COLS words
// hold the two previous rows; the arithmetic is a pipeline of difference,
// multiply, round and saturate registers with one 32x32 multiplier per derivative.
// APB: grid_rows, grid_cols, inv_row_spacing, inv_col_spacing at 0x0..0xC;
// writing either size restarts the frame. No clearing pass is needed.
// Reset (synchronous, active low) empties the pipeline, zeroes the position
// and restores default registers. A stalled receiver holds the output
// register; the pipeline fills behind it and then holds o_in_ready low.

module grid_gradient_stencil
    import ggs_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,

    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic signed [DATA_W-1:0] i_sample,

    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [IDX_W-1:0]         o_row_index,
    output logic [IDX_W-1:0]         o_col_index,
    output logic signed [DATA_W-1:0] o_row_gradient,
    output logic signed [DATA_W-1:0] o_col_gradient,
    output logic                     o_saturated,
    output logic                     o_last_of_run,
    output logic                     o_frame_end,

    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_AW-1:0]        paddr,
    input  logic [APB_DW-1:0]        pwdata,
    output logic [APB_DW-1:0]        prdata,
    output logic                     pready
);

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    logic [SIZE_W-1:0] r_grid_rows;
    logic [SIZE_W-1:0] r_grid_cols;
    logic [DATA_W-1:0] r_inv_row;
    logic [DATA_W-1:0] r_inv_col;

    t_reg_idx          w_reg_idx;
    logic              w_cfg_wr;
    logic              w_size_wr;

    assign pready    = 1'b1;
    assign w_reg_idx = t_reg_idx'(paddr[3:2]);
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_size_wr = w_cfg_wr && (w_reg_idx == REG_GRID_ROWS || w_reg_idx == REG_GRID_COLS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= GRID_SIZE_RESET;
            r_grid_cols <= GRID_SIZE_RESET;
            r_inv_row   <= INV_SPACE_RESET;
            r_inv_col   <= INV_SPACE_RESET;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_GRID_ROWS: r_grid_rows <= pwdata[SIZE_W-1:0];
                REG_GRID_COLS: r_grid_cols <= pwdata[SIZE_W-1:0];
                REG_INV_ROW:   r_inv_row   <= pwdata[DATA_W-1:0];
                REG_INV_COL:   r_inv_col   <= pwdata[DATA_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_GRID_ROWS: prdata = APB_DW'(r_grid_rows);
            REG_GRID_COLS: prdata = APB_DW'(r_grid_cols);
            REG_INV_ROW:   prdata = APB_DW'(r_inv_row);
            REG_INV_COL:   prdata = APB_DW'(r_inv_col);
        endcase
    end

    // clamp sizes into 2..MAX
    logic [RCNT_W-1:0] w_eff_rows;
    logic [CCNT_W-1:0] w_eff_cols;

    always_comb begin
        priority if (r_grid_rows < SIZE_W'(2)) begin
            w_eff_rows = RCNT_W'(2);
        end else if (int'(r_grid_rows) > MAX_ROWS) begin
            w_eff_rows = RCNT_W'(MAX_ROWS);
        end else begin
            w_eff_rows = RCNT_W'(r_grid_rows);
        end
        priority if (r_grid_cols < SIZE_W'(2)) begin
            w_eff_cols = CCNT_W'(2);
        end else if (int'(r_grid_cols) > MAX_COLS) begin
            w_eff_cols = CCNT_W'(MAX_COLS);
        end else begin
            w_eff_cols = CCNT_W'(r_grid_cols);
        end
    end

    // ------------------------------------------------------------------
    // pipeline handshake
    // ------------------------------------------------------------------
    logic             r_s1_valid;
    logic [NUM_PTS-1:0] r_job_mask;
    logic             r_d_valid;
    logic             r_m_valid;
    logic             r_r_valid;
    logic             r_o_valid;

    logic             w_o_free;
    logic             w_r_free;
    logic             w_m_free;
    logic             w_d_free;
    logic             w_issue;
    logic             w_job_single;
    logic             w_job_take;
    logic             w_accept;

    assign w_o_free     = !r_o_valid || i_out_ready;
    assign w_r_free     = !r_r_valid || w_o_free;
    assign w_m_free     = !r_m_valid || w_r_free;
    assign w_d_free     = !r_d_valid || w_m_free;
    assign w_issue      = (r_job_mask != '0) && w_d_free;
    assign w_job_single = (r_job_mask & (r_job_mask - NUM_PTS'(1))) == '0;
    // take the next sample once the current one issues its last point
    assign w_job_take   = r_s1_valid
                        && ((r_job_mask == '0) || (w_job_single && w_d_free));
    assign o_in_ready   = !r_s1_valid || w_job_take;
    assign w_accept     = i_in_valid && o_in_ready;

    // ------------------------------------------------------------------
    // raster position
    // ------------------------------------------------------------------
    logic [ROW_W-1:0] r_row_cnt;
    logic [COL_W-1:0] r_col_cnt;
    t_bank            r_bank;
    logic             w_last_row;
    logic             w_last_col;

    assign w_last_row = RCNT_W'(r_row_cnt) == (w_eff_rows - RCNT_W'(1));
    assign w_last_col = CCNT_W'(r_col_cnt) == (w_eff_cols - CCNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_size_wr) begin
            r_row_cnt <= '0;
            r_col_cnt <= '0;
            r_bank    <= '0;
        end else if (w_accept) begin
            if (!w_last_col) begin
                r_col_cnt <= r_col_cnt + COL_W'(1);
            end else begin
                r_col_cnt <= '0;
                if (w_last_row) begin
                    r_row_cnt <= '0;
                    r_bank    <= '0;
                end else begin
                    r_row_cnt <= r_row_cnt + ROW_W'(1);
                    r_bank    <= (r_bank == t_bank'(NUM_BANKS - 1)) ? '0 : r_bank + t_bank'(1);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // row banks: write the current row, read the two rows above
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] w_bank_rdata [NUM_BANKS];

    for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
        ggs_ram #(
            .WIDTH (DATA_W),
            .DEPTH (MAX_COLS)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_accept && (r_bank == t_bank'(b))),
            .i_waddr (r_col_cnt),
            .i_wdata (i_sample),
            .i_re    (w_accept && (r_bank != t_bank'(b))),
            .i_raddr (r_col_cnt),
            .o_rdata (w_bank_rdata[b])
        );
    end

    // ------------------------------------------------------------------
    // input register
    // ------------------------------------------------------------------
    logic signed [DATA_W-1:0] r_s1_sample;
    logic [ROW_W-1:0]         r_s1_row;
    logic [COL_W-1:0]         r_s1_col;
    t_bank                    r_s1_bank;
    logic                     r_s1_last_row;
    logic                     r_s1_last_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_sample   <= i_sample;
            r_s1_row      <= r_row_cnt;
            r_s1_col      <= r_col_cnt;
            r_s1_bank     <= r_bank;
            r_s1_last_row <= w_last_row;
            r_s1_last_col <= w_last_col;
        end
    end

    function automatic t_bank bank_above(input t_bank b);
        return (b == '0) ? t_bank'(NUM_BANKS - 1) : b - t_bank'(1);
    endfunction

    logic signed [DATA_W-1:0] w_mid_word;
    logic signed [DATA_W-1:0] w_top_word;
    logic [NUM_PTS-1:0]       w_new_mask;

    assign w_mid_word = w_bank_rdata[bank_above(r_s1_bank)];
    assign w_top_word = w_bank_rdata[bank_above(bank_above(r_s1_bank))];
    assign w_new_mask = (r_s1_row != '0 && r_s1_col != '0)
                      ? {r_s1_last_row && r_s1_last_col, r_s1_last_row, r_s1_last_col, 1'b1}
                      : '0;

    // ------------------------------------------------------------------
    // 3x3 window and point sequencer
    // top = row r-2, mid = row r-1, bot = row r; index 0 = column c
    // ------------------------------------------------------------------
    logic signed [DATA_W-1:0] r_win_top [2];
    logic signed [DATA_W-1:0] r_win_mid [3];
    logic signed [DATA_W-1:0] r_win_bot [3];
    logic [ROW_W-1:0]         r_job_row;
    logic [COL_W-1:0]         r_job_col;
    logic                     r_job_first_row;
    logic                     r_job_first_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_mask <= '0;
        end else if (w_job_take) begin
            r_job_mask <= w_new_mask;
        end else if (w_issue) begin
            r_job_mask <= r_job_mask & (r_job_mask - NUM_PTS'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_job_take) begin
            r_win_top[1]    <= r_win_top[0];
            r_win_top[0]    <= w_top_word;
            r_win_mid[2]    <= r_win_mid[1];
            r_win_mid[1]    <= r_win_mid[0];
            r_win_mid[0]    <= w_mid_word;
            r_win_bot[2]    <= r_win_bot[1];
            r_win_bot[1]    <= r_win_bot[0];
            r_win_bot[0]    <= r_s1_sample;
            r_job_row       <= r_s1_row;
            r_job_col       <= r_s1_col;
            r_job_first_row <= r_s1_row == ROW_W'(1);
            r_job_first_col <= r_s1_col == COL_W'(1);
        end
    end

    function automatic t_lane make_lane(input logic signed [DATA_W-1:0] a,
                                        input logic signed [DATA_W-1:0] b,
                                        input logic                     sh17);
        logic signed [DATA_W:0] ab;
        logic signed [DATA_W:0] ba;
        t_lane                  l;
        ab     = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        ba     = {b[DATA_W-1], b} - {a[DATA_W-1], a};
        l.neg  = ab[DATA_W];
        l.mag  = l.neg ? ba[DATA_W-1:0] : ab[DATA_W-1:0];
        l.sh17 = sh17;
        return l;
    endfunction

    t_lane w_lane_r;
    t_lane w_lane_c;
    t_tag  w_tag;

    always_comb begin
        w_tag.last = (r_job_mask & (r_job_mask - NUM_PTS'(1))) == '0;
        w_tag.fend = 1'b0;
        priority if (r_job_mask[0]) begin
            // point (r-1, c-1)
            w_tag.row = r_job_row - ROW_W'(1);
            w_tag.col = r_job_col - COL_W'(1);
            w_lane_r  = r_job_first_row
                      ? make_lane(r_win_bot[1], r_win_mid[1], 1'b0)
                      : make_lane(r_win_bot[1], r_win_top[1], 1'b1);
            w_lane_c  = r_job_first_col
                      ? make_lane(r_win_mid[0], r_win_mid[1], 1'b0)
                      : make_lane(r_win_mid[0], r_win_mid[2], 1'b1);
        end else if (r_job_mask[1]) begin
            // point (r-1, c), last column
            w_tag.row = r_job_row - ROW_W'(1);
            w_tag.col = r_job_col;
            w_lane_r  = r_job_first_row
                      ? make_lane(r_win_bot[0], r_win_mid[0], 1'b0)
                      : make_lane(r_win_bot[0], r_win_top[0], 1'b1);
            w_lane_c  = make_lane(r_win_mid[0], r_win_mid[1], 1'b0);
        end else if (r_job_mask[2]) begin
            // point (r, c-1), last row
            w_tag.row = r_job_row;
            w_tag.col = r_job_col - COL_W'(1);
            w_lane_r  = make_lane(r_win_bot[1], r_win_mid[1], 1'b0);
            w_lane_c  = r_job_first_col
                      ? make_lane(r_win_bot[0], r_win_bot[1], 1'b0)
                      : make_lane(r_win_bot[0], r_win_bot[2], 1'b1);
        end else begin
            // corner point (r, c)
            w_tag.row  = r_job_row;
            w_tag.col  = r_job_col;
            w_tag.fend = 1'b1;
            w_lane_r   = make_lane(r_win_bot[0], r_win_mid[0], 1'b0);
            w_lane_c   = make_lane(r_win_bot[0], r_win_bot[1], 1'b0);
        end
    end

    // ------------------------------------------------------------------
    // difference, multiply, round, saturate
    // ------------------------------------------------------------------
    t_lane             r_d_lane_r;
    t_lane             r_d_lane_c;
    t_tag              r_d_tag;
    logic [PROD_W-1:0] r_m_prod_r;
    logic [PROD_W-1:0] r_m_prod_c;
    logic [1:0]        r_m_neg;
    logic [1:0]        r_m_sh17;
    t_tag              r_m_tag;
    logic [QUOT_W-1:0] r_r_q_r;
    logic [QUOT_W-1:0] r_r_q_c;
    logic [1:0]        r_r_neg;
    t_tag              r_r_tag;

    logic [PROD_W-1:0] w_prod_r;
    logic [PROD_W-1:0] w_prod_c;

    assign w_prod_r = r_d_lane_r.mag * r_inv_row;
    assign w_prod_c = r_d_lane_c.mag * r_inv_col;

    function automatic logic [QUOT_W-1:0] round_q(input logic [PROD_W-1:0] p,
                                                 input logic              sh17);
        logic [PROD_W-1:0] s;
        s = p + (sh17 ? PROD_W'(32'h0001_0000) : PROD_W'(32'h0000_8000));
        return sh17 ? {1'b0, s[PROD_W-1:17]} : s[PROD_W-1:16];
    endfunction

    function automatic logic [DATA_W:0] clip_q(input logic [QUOT_W-1:0] q,
                                              input logic              neg);
        logic              sat;
        logic [DATA_W-1:0] v;
        if (!neg) begin
            sat = q[QUOT_W-1:DATA_W-1] != '0;
            v   = sat ? {1'b0, {(DATA_W-1){1'b1}}} : q[DATA_W-1:0];
        end else begin
            sat = (q[QUOT_W-1:DATA_W] != '0) || (q[DATA_W-1] && q[DATA_W-2:0] != '0);
            v   = sat ? {1'b1, {(DATA_W-1){1'b0}}} : DATA_W'(0) - q[DATA_W-1:0];
        end
        return {sat, v};
    endfunction

    logic [DATA_W:0] w_clip_r;
    logic [DATA_W:0] w_clip_c;

    assign w_clip_r = clip_q(r_r_q_r, r_r_neg[0]);
    assign w_clip_c = clip_q(r_r_q_c, r_r_neg[1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
            r_m_valid <= 1'b0;
            r_r_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (w_d_free) begin
                r_d_valid <= w_issue;
            end
            if (w_m_free) begin
                r_m_valid <= r_d_valid;
            end
            if (w_r_free) begin
                r_r_valid <= r_m_valid;
            end
            if (w_o_free) begin
                r_o_valid <= r_r_valid;
            end
        end
    end

    logic [DATA_W-1:0] r_o_grad_r;
    logic [DATA_W-1:0] r_o_grad_c;
    logic              r_o_sat;
    t_tag              r_o_tag;

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_d_lane_r <= w_lane_r;
            r_d_lane_c <= w_lane_c;
            r_d_tag    <= w_tag;
        end
        if (r_d_valid && w_m_free) begin
            r_m_prod_r <= w_prod_r;
            r_m_prod_c <= w_prod_c;
            r_m_neg    <= {r_d_lane_c.neg, r_d_lane_r.neg};
            r_m_sh17   <= {r_d_lane_c.sh17, r_d_lane_r.sh17};
            r_m_tag    <= r_d_tag;
        end
        if (r_m_valid && w_r_free) begin
            r_r_q_r <= round_q(r_m_prod_r, r_m_sh17[0]);
            r_r_q_c <= round_q(r_m_prod_c, r_m_sh17[1]);
            r_r_neg <= r_m_neg;
            r_r_tag <= r_m_tag;
        end
        if (r_r_valid && w_o_free) begin
            r_o_grad_r <= w_clip_r[DATA_W-1:0];
            r_o_grad_c <= w_clip_c[DATA_W-1:0];
            r_o_sat    <= w_clip_r[DATA_W] || w_clip_c[DATA_W];
            r_o_tag    <= r_r_tag;
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_row_index    = r_o_tag.row;
    assign o_col_index    = r_o_tag.col;
    assign o_row_gradient = r_o_grad_r;
    assign o_col_gradient = r_o_grad_c;
    assign o_saturated    = r_o_sat;
    assign o_last_of_run  = r_o_tag.last;
    assign o_frame_end    = r_o_tag.fend;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (RCNT_W'(r_row_cnt) < w_eff_rows) && (CCNT_W'(r_col_cnt) < w_eff_cols))
        else $error("raster position outside the grid");

    a_bank_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bank != t_bank'(NUM_BANKS) && r_s1_bank != t_bank'(NUM_BANKS) || !r_s1_valid)
        else $error("row bank index out of range");

    // the row neighbor is issued just ahead of the corner
    a_corner_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_mask[3] && (r_job_mask[1:0] != 2'b00) |-> r_job_mask[2])
        else $error("corner point pending without its row neighbor");

    a_fend_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_tag.fend |-> r_o_tag.last)
        else $error("frame end result not last of its run");

    a_take_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && (r_job_mask != '0) && !w_d_free |=> r_s1_valid)
        else $error("sample left the input register while points were pending");

endmodule
